[rtl/dsi2d_pkg.sv]
// Package for the two-axis damped spring integrator.
// Widths, fixed-point constants, item kinds, register indexes and controller state type.
// Every other file in rtl/ imports it; it depends on nothing.
package dsi2d_pkg;

  localparam int FracBits    = 16;
  localparam int MaxStep     = 546;
  localparam int SettleLimit = 33;

  localparam int ScaleW = 20;
  localparam int VelW   = 24;
  localparam int CoefW  = 24;
  localparam int KW     = 20;
  localparam int DrW    = 16;
  localparam int TimeW  = 16;
  localparam int KFrac    = 8;
  localparam int CoefFrac = 14;
  localparam int TimeFrac = 16;

  // The radicand is stiffness << 20, which is 40 bits; its root fits in 20 bits.
  localparam int RadW  = 40;
  localparam int RootW = 20;

  localparam int StiffRst = 61440;
  localparam int DampRst  = 5243;

  localparam logic [ScaleW-1:0] ScaleMax = {1'b0, {(ScaleW-1){1'b1}}};
  localparam logic [ScaleW-1:0] ScaleMin = {1'b1, {(ScaleW-1){1'b0}}};

  // 1.0 is 2^FracBits, held at the top of the scale range when it does not fit.
  function automatic logic [ScaleW-1:0] unit_value();
    logic [ScaleW-1:0] u;
    if (FracBits >= ScaleW - 1) begin
      u = ScaleMax;
    end else begin
      u = ScaleW'(1) << FracBits;
    end
    return u;
  endfunction

  typedef enum logic [1:0] {
    KIND_UPDATE = 2'd0,
    KIND_PUNCH  = 2'd1,
    KIND_TARGET = 2'd2,
    KIND_RESET  = 2'd3
  } kind_t;

  localparam logic REG_STIFFNESS = 1'b0;
  localparam logic REG_DAMPING   = 1'b1;

  typedef enum logic [3:0] {
    ST_COEF_START,
    ST_COEF_RUN,
    ST_COEF_MUL,
    ST_COEF_SHIFT,
    ST_IDLE,
    ST_MUL_A,
    ST_SUM_A,
    ST_MUL_V,
    ST_UPD_V,
    ST_MUL_S,
    ST_UPD_S,
    ST_SETTLE,
    ST_OUT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load_item;   // register the accepted transaction's operands
    logic       apply_kind;  // punch, set target or reset on the motion state
    logic       sqrt_init;   // load the square root iteration
    logic       sqrt_step;   // one result bit of the square root
    logic       coef_mul;    // damping_ratio * root
    logic       coef_shift;  // scale and saturate into damping_coef
    logic       step_load;   // take the next substep from the remaining time
    logic       mul_a;       // k*err and c*vel for the current axis
    logic       sum_a;       // acceleration
    logic       mul_v;       // accel*step
    logic       upd_v;       // velocity update
    logic       mul_s;       // velocity*step
    logic       upd_s;       // scale update
    logic       axis;        // current axis, 0 is x
    logic       settle;      // snap both axes where settled
    logic       out_load;    // capture the result transaction
  } dsi2d_cmd_t;

  typedef struct packed {
    logic sqrt_done;
    logic time_left;   // more time remains after the current substep
  } dsi2d_sts_t;

  localparam int SqrtIter = RootW;
  localparam int SqrtCntW = $clog2(SqrtIter + 1);

endpackage

[rtl/dsi2d_datapath.sv]
// Datapath of the two-axis damped spring integrator: motion state, registers,
// shared multipliers, a bit-serial square root and the result register.
// Depends on dsi2d_pkg; driven by dsi2d_ctrl through dsi2d_cmd_t.
module dsi2d_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  dsi2d_pkg::dsi2d_cmd_t            cmd,
  output dsi2d_pkg::dsi2d_sts_t            sts,
  input  logic                             cfg_we,
  input  logic                             cfg_idx,
  input  logic [dsi2d_pkg::KW-1:0]         cfg_data,
  input  logic [1:0]                       in_kind,
  input  logic [dsi2d_pkg::TimeW-1:0]      in_dt,
  input  logic signed [dsi2d_pkg::ScaleW-1:0] in_vx,
  input  logic signed [dsi2d_pkg::ScaleW-1:0] in_vy,
  output logic signed [dsi2d_pkg::ScaleW-1:0] out_sx,
  output logic signed [dsi2d_pkg::ScaleW-1:0] out_sy,
  output logic                             out_tx,
  output logic                             out_ty
);
  import dsi2d_pkg::*;

  localparam int ErrW   = ScaleW + 1;
  localparam int KProdW = KW + 1 + ErrW;        // signed k*err
  localparam int CProdW = CoefW + 1 + VelW;     // signed c*vel
  localparam int AccW   = CProdW + 1;
  localparam int StepW  = TimeW;
  localparam int AProdW = AccW + StepW + 1;
  localparam int VProdW = VelW + StepW + 1;

  // Signed saturation bounds at the widths of the two sums.
  localparam logic signed [AProdW-TimeFrac:0] VSatHi =
    (AProdW-TimeFrac+1)'((64'sd1 <<< (VelW-1)) - 64'sd1);
  localparam logic signed [AProdW-TimeFrac:0] VSatLo =
    -VSatHi - (AProdW-TimeFrac+1)'(1);
  localparam logic signed [VProdW-TimeFrac:0] SSatHi =
    (VProdW-TimeFrac+1)'((64'sd1 <<< (ScaleW-1)) - 64'sd1);
  localparam logic signed [VProdW-TimeFrac:0] SSatLo =
    -SSatHi - (VProdW-TimeFrac+1)'(1);

  logic [KW-1:0]    stiffness;
  logic [DrW-1:0]   damping_ratio;
  logic [CoefW-1:0] damping_coef;

  logic signed [ScaleW-1:0] scale  [2];
  logic signed [VelW-1:0]   vel    [2];
  logic signed [ScaleW-1:0] target [2];

  logic [1:0]               kind_r;
  logic [TimeW-1:0]         rem;
  logic [StepW-1:0]         step;
  logic signed [ScaleW-1:0] vx_r, vy_r;

  // Square root, one result bit a cycle (restoring, two radicand bits a step).
  logic [RadW-1:0]    sq_rad;
  logic [RootW+1:0]   sq_rem;
  logic [RootW-1:0]   sq_root;
  logic [SqrtCntW-1:0] sq_cnt;
  logic [RootW+1:0]   sq_trial;
  logic [RootW+1:0]   sq_cur;
  logic [DrW+RootW+1:0] coef_prod;
  logic [DrW+RootW+1:0] coef_sh;

  logic signed [KProdW-1:0] kprod;
  logic signed [CProdW-1:0] cprod;
  logic signed [AccW-1:0]   accel;
  logic signed [AProdW-1:0] aprod;
  logic signed [VProdW-1:0] vprod;

  logic signed [ScaleW-1:0] s_cur, t_cur;
  logic signed [VelW-1:0]   v_cur;
  logic signed [ErrW-1:0]   err;
  logic signed [AProdW-TimeFrac:0] v_sum;
  logic signed [VProdW-TimeFrac:0] s_sum;
  logic signed [VelW-1:0]   v_new;
  logic signed [ScaleW-1:0] s_new;
  logic [TimeW-1:0]         step_next;

  assign s_cur = scale[cmd.axis];
  assign v_cur = vel[cmd.axis];
  assign t_cur = target[cmd.axis];
  assign err   = ErrW'(s_cur) - ErrW'(t_cur);

  assign sq_cur   = {sq_rem[RootW-1:0], sq_rad[RadW-1 -: 2]};
  assign sq_trial = {sq_root, 2'b01};
  assign coef_sh  = coef_prod >> CoefFrac;

  // Arithmetic shift is a floor toward minus infinity.
  assign v_sum = (AProdW-TimeFrac+1)'(v_cur) + (AProdW-TimeFrac+1)'(aprod >>> TimeFrac);
  assign s_sum = (VProdW-TimeFrac+1)'(s_cur) + (VProdW-TimeFrac+1)'(vprod >>> TimeFrac);

  always_comb begin
    if (v_sum > VSatHi) begin
      v_new = {1'b0, {(VelW-1){1'b1}}};
    end else if (v_sum < VSatLo) begin
      v_new = {1'b1, {(VelW-1){1'b0}}};
    end else begin
      v_new = v_sum[VelW-1:0];
    end
    if (s_sum > SSatHi) begin
      s_new = ScaleMax;
    end else if (s_sum < SSatLo) begin
      s_new = ScaleMin;
    end else begin
      s_new = s_sum[ScaleW-1:0];
    end
    step_next = (rem < TimeW'(MaxStep)) ? rem : TimeW'(MaxStep);
  end

  assign sts.sqrt_done = (sq_cnt == '0);
  assign sts.time_left = (rem != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      stiffness     <= KW'(StiffRst);
      damping_ratio <= DrW'(DampRst);
      for (int a = 0; a < 2; a++) begin
        scale[a]  <= unit_value();
        vel[a]    <= '0;
        target[a] <= unit_value();
      end
      sq_cnt <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_idx == REG_STIFFNESS) begin
          stiffness <= cfg_data;
        end else begin
          damping_ratio <= cfg_data[DrW-1:0];
        end
      end
      if (cmd.sqrt_init) begin
        sq_rad  <= {stiffness, 20'd0};
        sq_rem  <= '0;
        sq_root <= '0;
        sq_cnt  <= SqrtCntW'(SqrtIter);
      end else if (cmd.sqrt_step) begin
        sq_rad <= sq_rad << 2;
        sq_cnt <= sq_cnt - 1'b1;
        if (sq_cur >= sq_trial) begin
          sq_rem  <= sq_cur - sq_trial;
          sq_root <= {sq_root[RootW-2:0], 1'b1};
        end else begin
          sq_rem  <= sq_cur;
          sq_root <= {sq_root[RootW-2:0], 1'b0};
        end
      end
      if (cmd.apply_kind) begin
        unique case (kind_t'(kind_r))
          KIND_PUNCH: begin
            scale[0] <= vx_r;
            scale[1] <= vy_r;
            for (int a = 0; a < 2; a++) begin
              vel[a]    <= '0;
              target[a] <= unit_value();
            end
          end
          KIND_TARGET: begin
            target[0] <= vx_r;
            target[1] <= vy_r;
          end
          KIND_RESET: begin
            for (int a = 0; a < 2; a++) begin
              scale[a]  <= unit_value();
              vel[a]    <= '0;
              target[a] <= unit_value();
            end
          end
          default: begin
          end
        endcase
      end
      if (cmd.upd_v) begin
        vel[cmd.axis] <= v_new;
      end
      if (cmd.upd_s) begin
        scale[cmd.axis] <= s_new;
      end
      if (cmd.settle) begin
        for (int a = 0; a < 2; a++) begin
          if ((ErrW'(scale[a]) - ErrW'(target[a]) < ErrW'(SettleLimit)) &&
              (ErrW'(target[a]) - ErrW'(scale[a]) < ErrW'(SettleLimit)) &&
              (vel[a] < VelW'(SettleLimit)) && (vel[a] > -VelW'(SettleLimit))) begin
            scale[a] <= target[a];
            vel[a]   <= '0;
          end
        end
      end
    end
  end

  // Payload and work registers need no reset.
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      kind_r <= in_kind;
      rem    <= in_dt;
      vx_r   <= in_vx;
      vy_r   <= in_vy;
    end else if (cmd.step_load) begin
      step <= step_next;
      rem  <= rem - step_next;
    end
    if (cmd.coef_mul) begin
      coef_prod <= (DrW+RootW+2)'(damping_ratio) * (DrW+RootW+2)'(sq_root) * 2;
    end
    if (cmd.coef_shift) begin
      damping_coef <= (coef_sh > (DrW+RootW+2)'({CoefW{1'b1}})) ? {CoefW{1'b1}}
                                                                : coef_sh[CoefW-1:0];
    end
    if (cmd.mul_a) begin
      kprod <= $signed({1'b0, stiffness}) * err;
      cprod <= $signed({1'b0, damping_coef}) * v_cur;
    end
    if (cmd.sum_a) begin
      accel <= -AccW'(kprod >>> KFrac) - AccW'(cprod >>> CoefFrac);
    end
    if (cmd.mul_v) begin
      aprod <= accel * $signed({1'b0, step});
    end
    if (cmd.mul_s) begin
      vprod <= v_cur * $signed({1'b0, step});
    end
    if (cmd.out_load) begin
      out_sx <= scale[0];
      out_sy <= scale[1];
      out_tx <= (scale[0] == target[0]) && (vel[0] == '0);
      out_ty <= (scale[1] == target[1]) && (vel[1] == '0);
    end
  end

endmodule

[rtl/dsi2d_ctrl.sv]
// Controller of the two-axis damped spring integrator: sequences the
// coefficient computation, the substep loop and the result handshake.
// Depends on dsi2d_pkg; commands dsi2d_datapath.
module dsi2d_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_kind,
  input  logic [dsi2d_pkg::TimeW-1:0] in_dt,
  output logic                  out_valid,
  input  logic                  out_stall,
  input  logic                  cfg_we,
  output logic                  cfg_ready,
  output dsi2d_pkg::dsi2d_cmd_t cmd,
  input  dsi2d_pkg::dsi2d_sts_t sts
);
  import dsi2d_pkg::*;

  state_t state, state_next;
  logic   axis, axis_next;
  logic   is_update;
  logic   busy;
  logic   accept;

  assign accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_COEF_START;
      axis      <= 1'b0;
      out_valid <= 1'b0;
      is_update <= 1'b0;
    end else begin
      state <= state_next;
      axis  <= axis_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (accept) begin
        is_update <= (kind_t'(in_kind) == KIND_UPDATE) && (in_dt != '0);
      end
    end
  end

  // A result waiting in the output register does not hold up new work,
  // except that a new result cannot be written over it.
  // An offered input transaction takes precedence over a register write.
  assign busy      = out_valid && out_stall;
  assign in_stall  = (state != ST_IDLE);
  assign cfg_ready = (state == ST_IDLE) && !out_valid && !in_valid;

  always_comb begin
    state_next = state;
    axis_next  = axis;
    cmd        = '0;
    cmd.axis   = axis;
    unique case (state)
      ST_COEF_START: begin
        cmd.sqrt_init = 1'b1;
        state_next    = ST_COEF_RUN;
      end
      ST_COEF_RUN: begin
        if (sts.sqrt_done) begin
          state_next = ST_COEF_MUL;
        end else begin
          cmd.sqrt_step = 1'b1;
        end
      end
      ST_COEF_MUL: begin
        cmd.coef_mul = 1'b1;
        state_next   = ST_COEF_SHIFT;
      end
      ST_COEF_SHIFT: begin
        cmd.coef_shift = 1'b1;
        state_next     = ST_IDLE;
      end
      ST_IDLE: begin
        if (cfg_we) begin
          state_next = ST_COEF_START;
        end else if (in_valid) begin
          cmd.load_item = 1'b1;
          if ((kind_t'(in_kind) == KIND_UPDATE) && (in_dt != '0)) begin
            state_next = ST_MUL_A;
          end else begin
            state_next = ST_SETTLE;
          end
        end
      end
      ST_MUL_A: begin
        // The first pass on x takes the next substep length.
        if (!axis) begin
          cmd.step_load = 1'b1;
        end
        cmd.mul_a  = 1'b1;
        state_next = ST_SUM_A;
      end
      ST_SUM_A: begin
        cmd.sum_a  = 1'b1;
        state_next = ST_MUL_V;
      end
      ST_MUL_V: begin
        cmd.mul_v  = 1'b1;
        state_next = ST_UPD_V;
      end
      ST_UPD_V: begin
        cmd.upd_v  = 1'b1;
        state_next = ST_MUL_S;
      end
      ST_MUL_S: begin
        cmd.mul_s  = 1'b1;
        state_next = ST_UPD_S;
      end
      ST_UPD_S: begin
        cmd.upd_s = 1'b1;
        axis_next = ~axis;
        if (axis && !sts.time_left) begin
          state_next = ST_SETTLE;
        end else begin
          state_next = ST_MUL_A;
        end
      end
      ST_SETTLE: begin
        // For update items this is the settle test; other kinds apply here.
        cmd.settle     = is_update;
        cmd.apply_kind = !is_update;
        state_next     = ST_OUT;
      end
      ST_OUT: begin
        if (!busy) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  a_axis_x_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !axis)
    else $error("axis not back on x at idle");

  a_one_result: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> (state == ST_IDLE) && out_valid)
    else $error("result not presented after load");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !(out_valid && out_stall))
    else $error("pending result overwritten");

  a_cfg_idle: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> (state == ST_COEF_START))
    else $error("coefficient not recomputed after write");

endmodule

[rtl/damped_spring_integrator_2d_core.sv]
// Top level of the two-axis damped spring integrator (semi-implicit Euler).
// Every item ends in settle and output; a timed update first runs acceleration, velocity
// and scale steps per axis per substep (ceil(delta_time/546) substeps); one item at a
// time through the shared multipliers. After reset and after each register write the
// damping coefficient is recomputed (bit-serial square root) before the next transaction;
// reset restores the default state.
module damped_spring_integrator_2d_core (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic [1:0] kind,
  input  logic [dsi2d_pkg::TimeW-1:0] delta_time,
  input  logic signed [dsi2d_pkg::ScaleW-1:0] value_x,
  input  logic signed [dsi2d_pkg::ScaleW-1:0] value_y,
  output logic out_valid,
  input  logic out_stall,
  output logic signed [dsi2d_pkg::ScaleW-1:0] scale_x,
  output logic signed [dsi2d_pkg::ScaleW-1:0] scale_y,
  output logic settled_x,
  output logic settled_y,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [0:0] cfg_index,
  input  logic [dsi2d_pkg::KW-1:0] cfg_data
);
  import dsi2d_pkg::*;

  dsi2d_cmd_t cmd;
  dsi2d_sts_t sts;
  logic       cfg_we;

  assign cfg_we = cfg_valid && cfg_ready;

  dsi2d_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_kind   (kind),
    .in_dt     (delta_time),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cfg_we    (cfg_we),
    .cfg_ready (cfg_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  dsi2d_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_index[0]),
    .cfg_data (cfg_data),
    .in_kind  (kind),
    .in_dt    (delta_time),
    .in_vx    (value_x),
    .in_vy    (value_y),
    .out_sx   (scale_x),
    .out_sy   (scale_y),
    .out_tx   (settled_x),
    .out_ty   (settled_y)
  );

endmodule

[test/tb_damped_spring_integrator_2d_core.sv]
// Self-checking testbench for damped_spring_integrator_2d_core: drives update, punch, set-target
// and reset transactions with random idling and register writes, and predicts every result.
// Depends on rtl/dsi2d_pkg.sv and the RTL of the core; reads no files.
module tb_damped_spring_integrator_2d_core;
  timeunit 1ns;
  timeprecision 1ps;
  import dsi2d_pkg::*;

  typedef struct {
    logic signed [ScaleW-1:0] sx;
    logic signed [ScaleW-1:0] sy;
    logic                     stx;
    logic                     sty;
  } spring_result_t;

  class spring_scoreboard;
    longint stiff, damp, coef;
    longint scl[2], vel[2], tgt[2];
    spring_result_t pending[$];
    int mismatches;
    int failures;

    function new();
      stiff = StiffRst;
      damp = DampRst;
      update_coef();
      home();
    endfunction

    function longint sat(longint v, int w);
      longint hi, lo;
      hi = (longint'(1) <<< (w - 1)) - 1;
      lo = -hi - 1;
      return (v > hi) ? hi : ((v < lo) ? lo : v);
    endfunction

    function void update_coef();
      longint v, r, b, c;
      v = stiff <<< 20;
      r = 0;
      b = longint'(1) <<< 62;
      while (b > v) b = b >>> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >>> 1) + b;
        end else begin
          r = r >>> 1;
        end
        b = b >>> 2;
      end
      c = (2 * damp * r) >>> CoefFrac;
      coef = (c > 16777215) ? 16777215 : c;
    endfunction

    function void home();
      for (int a = 0; a < 2; a++) begin
        scl[a] = 65536;
        vel[a] = 0;
        tgt[a] = 65536;
      end
    endfunction

    function void write_reg(logic [0:0] idx, logic [KW-1:0] data);
      if (idx == REG_STIFFNESS) stiff = data;
      else damp = data[DrW-1:0];
      update_coef();
    endfunction

    function void integrate(int a, longint stp);
      longint err, acc;
      err = scl[a] - tgt[a];
      acc = -((stiff * err) >>> KFrac) - ((coef * vel[a]) >>> CoefFrac);
      vel[a] = sat(vel[a] + ((acc * stp) >>> TimeFrac), VelW);
      scl[a] = sat(scl[a] + ((vel[a] * stp) >>> TimeFrac), ScaleW);
    endfunction

    // Called once per accepted input transaction.
    function void note_item(kind_t k, logic [TimeW-1:0] dt,
                            logic signed [ScaleW-1:0] vx, logic signed [ScaleW-1:0] vy);
      spring_result_t r;
      longint rem, stp, e, v;
      case (k)
        KIND_UPDATE: begin
          if (dt != 0) begin
            rem = dt;
            while (rem > 0) begin
              stp = (rem < MaxStep) ? rem : MaxStep;
              rem -= stp;
              integrate(0, stp);
              integrate(1, stp);
            end
            for (int a = 0; a < 2; a++) begin
              e = scl[a] - tgt[a];
              v = vel[a];
              if (e < 0) e = -e;
              if (v < 0) v = -v;
              if (e < SettleLimit && v < SettleLimit) begin
                scl[a] = tgt[a];
                vel[a] = 0;
              end
            end
          end
        end
        KIND_PUNCH: begin
          scl[0] = vx;
          scl[1] = vy;
          vel[0] = 0;
          vel[1] = 0;
          tgt[0] = 65536;
          tgt[1] = 65536;
        end
        KIND_TARGET: begin
          tgt[0] = vx;
          tgt[1] = vy;
        end
        default: home();
      endcase
      r.sx = scl[0][ScaleW-1:0];
      r.sy = scl[1][ScaleW-1:0];
      r.stx = (scl[0] == tgt[0]) && (vel[0] == 0);
      r.sty = (scl[1] == tgt[1]) && (vel[1] == 0);
      pending.push_back(r);
    endfunction

    function void check_result(spring_result_t got);
      spring_result_t want;
      if (pending.size() == 0) begin
        failures++;
        $display("unexpected result transaction: scale %0d,%0d", got.sx, got.sy);
        return;
      end
      want = pending.pop_front();
      if (got.sx !== want.sx || got.sy !== want.sy ||
          got.stx !== want.stx || got.sty !== want.sty) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: scale %0d,%0d settled %b%b, expected %0d,%0d settled %b%b",
                   got.sx, got.sy, got.stx, got.sty, want.sx, want.sy, want.stx, want.sty);
      end
    endfunction
  endclass

  logic clk, rst;
  logic in_valid, in_stall;
  logic [1:0] kind;
  logic [TimeW-1:0] delta_time;
  logic signed [ScaleW-1:0] value_x, value_y;
  logic out_valid, out_stall;
  logic signed [ScaleW-1:0] scale_x, scale_y;
  logic settled_x, settled_y;
  logic cfg_valid, cfg_ready;
  logic [0:0] cfg_index;
  logic [KW-1:0] cfg_data;

  damped_spring_integrator_2d_core uut (.*);

  spring_scoreboard sb = new();
  bit quiet;          // no idling on either side while set
  int hold_cycles;    // one-off long stall requested of the receiver
  int idle_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    kind = KIND_UPDATE;
    delta_time = '0;
    value_x = '0;
    value_y = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
  end

  // Receiver: random stall before each result transaction.
  initial begin
    int w;
    spring_result_t got;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      w = quiet ? 0 : $urandom_range(0, 15);
      if (hold_cycles > 0) begin
        w = hold_cycles;
        hold_cycles = 0;
      end
      out_stall = (w != 0);
      repeat (w) @(negedge clk);
      out_stall = 1'b0;
      do @(posedge clk); while (!out_valid);
      got.sx = scale_x;
      got.sy = scale_y;
      got.stx = settled_x;
      got.sty = settled_y;
      sb.check_result(got);
      @(negedge clk);
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == 30000) begin
      $display("tb_damped_spring_integrator_2d_core NOT OK");
      $finish;
    end
  end

  // Called and returns at a falling edge; valid stays high for a back-to-back transaction.
  task automatic send(kind_t k, logic [TimeW-1:0] dt, logic [ScaleW-1:0] vx,
                      logic [ScaleW-1:0] vy);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    kind = k;
    delta_time = dt;
    value_x = vx;
    value_y = vy;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note_item(k, dt, vx, vy);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [KW-1:0] data);
    cfg_index = idx;
    cfg_data = data;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [ScaleW-1:0] near_unit();
    return ScaleW'(65536 + $signed($urandom_range(0, 65535)) - 32768);
  endfunction

  // Mostly animation-like sequences: a punch or target change followed by frame updates.
  task automatic random_items(int n);
    int r;
    logic [TimeW-1:0] dt;
    for (int i = 0; i < n; i++) begin
      if (($urandom_range(0, 63)) == 0) quiet = !quiet;
      r = $urandom_range(0, 99);
      if (r < 6) begin
        send(KIND_PUNCH, TimeW'($urandom), near_unit(), near_unit());
      end else if (r < 9) begin
        send(KIND_TARGET, TimeW'($urandom), near_unit(), near_unit());
      end else if (r < 11) begin
        send(KIND_RESET, TimeW'($urandom), ScaleW'($urandom), ScaleW'($urandom));
      end else if (r < 15) begin
        send(kind_t'($urandom_range(1, 2)), TimeW'($urandom), ScaleW'($urandom),
             ScaleW'($urandom));
      end else begin
        if (r < 17) dt = TimeW'($urandom);
        else if (r < 20) dt = TimeW'($urandom_range(0, 3));
        else dt = TimeW'($urandom_range(300, 2300));
        send(KIND_UPDATE, dt, ScaleW'($urandom), ScaleW'($urandom));
      end
    end
  endtask

  task automatic phase(logic [KW-1:0] k, logic [KW-1:0] d, int n);
    drain();
    write_reg(REG_STIFFNESS, k);
    write_reg(REG_DAMPING, d);
    random_items(n);
  endtask

  initial begin
    quiet = 1'b0;
    hold_cycles = 0;
    @(negedge clk);
    while (rst) @(negedge clk);

    // Directed: extremes of each field, every kind, zero and split time steps, settling.
    send(KIND_UPDATE, 16'd0, 20'h7FFFF, 20'h80000);
    send(KIND_UPDATE, 16'd1, 20'h00000, 20'hFFFFF);
    send(KIND_PUNCH, 16'hFFFF, 20'h7FFFF, 20'h80000);
    send(KIND_UPDATE, 16'd546, 20'd0, 20'd0);
    send(KIND_UPDATE, 16'd547, 20'd0, 20'd0);
    send(KIND_UPDATE, 16'hFFFF, 20'd0, 20'd0);
    send(KIND_TARGET, 16'd0, 20'h80000, 20'h7FFFF);
    send(KIND_UPDATE, 16'hFFFF, 20'd0, 20'd0);
    send(KIND_UPDATE, 16'd0, 20'd0, 20'd0);
    send(KIND_RESET, 16'hFFFF, 20'hFFFFF, 20'hFFFFF);
    send(KIND_PUNCH, 16'd0, 20'd65546, 20'd65526);
    send(KIND_UPDATE, 16'd1, 20'd0, 20'd0);
    send(KIND_PUNCH, 16'd0, 20'd80000, 20'd50000);
    for (int i = 0; i < 8; i++) send(KIND_UPDATE, 16'd8192, 20'd0, 20'd0);
    send(KIND_TARGET, 16'd0, 20'd65536, 20'd0);
    send(KIND_UPDATE, 16'd1092, 20'd0, 20'd0);

    // Receiver holds off while the sender keeps offering, so the input stalls.
    drain();
    hold_cycles = 400;
    @(negedge clk);
    quiet = 1'b1;
    for (int i = 0; i < 12; i++) send(KIND_UPDATE, 16'd300, 20'd0, 20'd0);
    quiet = 1'b0;

    phase(20'd61440, 20'd5243, 200);
    phase(20'd0, 20'd0, 150);
    phase(20'hFFFFF, 20'hFFFF, 150);
    phase(20'd4096, 20'd16384, 200);
    phase(20'hFFFFF, 20'd0, 100);
    phase(20'd0, 20'hFFFF, 100);
    phase(KW'($urandom), KW'($urandom), 150);

    drain();
    repeat (1500) @(posedge clk);
    if (sb.mismatches == 0 && sb.failures == 0 && sb.pending.size() == 0) begin
      $display("tb_damped_spring_integrator_2d_core OK");
    end else begin
      $display("tb_damped_spring_integrator_2d_core NOT OK");
    end
    $finish;
  end

endmodule
